// ===== rtl/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types and constants of the line follower PID drive block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SETUP,
        ST_DIV,
        ST_ERR,
        ST_PID,
        ST_DRIVE
    } t_state;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_BASE_DRIVE,
        REG_DRIVE_FLOOR,
        REG_DRIVE_CEILING,
        REG_DARK_THRESHOLD,
        REG_INTEGRAL_LIMIT
    } t_reg_idx;

    // Channel payloads
    typedef struct packed {
        logic [11:0] reading_a;
        logic [11:0] reading_b;
        logic [11:0] reading_c;
        logic [11:0] reading_d;
    } t_reading_item;

    typedef struct packed {
        logic [14:0]        left_drive;
        logic [14:0]        right_drive;
        logic signed [15:0] steer_correction;
        logic               line_lost;
    } t_drive_item;

    typedef struct packed {
        t_reg_idx    index;
        logic [15:0] wdata;
    } t_cfg_item;

    // Register file contents
    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [14:0] base_drive;
        logic [14:0] drive_floor;
        logic [14:0] drive_ceiling;
        logic [9:0]  dark_threshold;
        logic [14:0] integral_limit;
    } t_cfg_regs;

    // Divider request
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [11:0] divisor;
    } t_div_req;

    // Register reset values
    localparam logic [15:0] RST_GAIN_P         = 16'd256;
    localparam logic [15:0] RST_GAIN_I         = 16'd0;
    localparam logic [15:0] RST_GAIN_D         = 16'd384;
    localparam logic [14:0] RST_BASE_DRIVE     = 15'd19200;
    localparam logic [14:0] RST_DRIVE_FLOOR    = 15'd16640;
    localparam logic [14:0] RST_DRIVE_CEILING  = 15'd21760;
    localparam logic [9:0]  RST_DARK_THRESHOLD = 10'd400;
    localparam logic [14:0] RST_INTEGRAL_LIMIT = 15'd7680;

    // Normalization: level = ((raw - 1700) * 10) / 23, via reciprocal 2^19/23 rounded up
    localparam logic [11:0]        RAW_LOW    = 12'd1700;
    localparam logic [9:0]         LEVEL_MAX  = 10'd1000;
    localparam logic signed [16:0] NORM_RECIP = 17'sd22796;
    localparam int                 NORM_SHIFT = 19;

    // Position division: quotient fits 13 bits, one bit per step
    localparam logic [3:0] DIV_STEPS = 4'd13;

    // Error used when the line is lost (2.5 * 10 in Q8)
    localparam logic signed [13:0] LOST_ERROR = 14'sd6400;

    // Fraction bits of the gains
    localparam int MIX_FRAC = 8;

endpackage

// ===== rtl/lfpd_chan_if.sv =====
// ----------------------------------------------------------------------------
// lfpd_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lfpd_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lfpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lfpd_cfg_regs
// Configuration register file, written by index over its own channel.
// ----------------------------------------------------------------------------
module lfpd_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lfpd_chan_if.sink         i_cfg,
    output lfpd_pkg::t_cfg_regs o_regs
);

    lfpd_pkg::t_cfg_regs r_regs;

    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.gain_p         <= lfpd_pkg::RST_GAIN_P;
            r_regs.gain_i         <= lfpd_pkg::RST_GAIN_I;
            r_regs.gain_d         <= lfpd_pkg::RST_GAIN_D;
            r_regs.base_drive     <= lfpd_pkg::RST_BASE_DRIVE;
            r_regs.drive_floor    <= lfpd_pkg::RST_DRIVE_FLOOR;
            r_regs.drive_ceiling  <= lfpd_pkg::RST_DRIVE_CEILING;
            r_regs.dark_threshold <= lfpd_pkg::RST_DARK_THRESHOLD;
            r_regs.integral_limit <= lfpd_pkg::RST_INTEGRAL_LIMIT;
        end else if (i_cfg.valid) begin
            // keep only the bits each register holds
            case (i_cfg.data.index)
                lfpd_pkg::REG_GAIN_P:         r_regs.gain_p         <= i_cfg.data.wdata;
                lfpd_pkg::REG_GAIN_I:         r_regs.gain_i         <= i_cfg.data.wdata;
                lfpd_pkg::REG_GAIN_D:         r_regs.gain_d         <= i_cfg.data.wdata;
                lfpd_pkg::REG_BASE_DRIVE:     r_regs.base_drive     <= i_cfg.data.wdata[14:0];
                lfpd_pkg::REG_DRIVE_FLOOR:    r_regs.drive_floor    <= i_cfg.data.wdata[14:0];
                lfpd_pkg::REG_DRIVE_CEILING:  r_regs.drive_ceiling  <= i_cfg.data.wdata[14:0];
                lfpd_pkg::REG_DARK_THRESHOLD: r_regs.dark_threshold <= i_cfg.data.wdata[9:0];
                lfpd_pkg::REG_INTEGRAL_LIMIT: r_regs.integral_limit <= i_cfg.data.wdata[14:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/lfpd_mult.sv =====
// ----------------------------------------------------------------------------
// lfpd_mult
// Shared signed 17x17 multiplier with a registered product.
// ----------------------------------------------------------------------------
module lfpd_mult (
    input  logic               i_clk,
    input  logic signed [16:0] i_a,
    input  logic signed [16:0] i_b,
    output logic signed [33:0] o_prod
);

    logic signed [33:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/lfpd_div.sv =====
// ----------------------------------------------------------------------------
// lfpd_div
// Restoring serial divider, one quotient bit per cycle, 13-bit quotient.
// ----------------------------------------------------------------------------
module lfpd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfpd_pkg::t_div_req i_req,
    output logic [12:0]        o_quotient,
    output logic               o_done
);

    logic [3:0]  r_count;
    logic [11:0] r_rem;
    logic [12:0] r_quo;
    logic [11:0] r_dvs;

    logic [12:0] trial;
    logic [12:0] trial_sub;
    logic        take;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        trial     = {r_rem, r_quo[12]};
        trial_sub = trial - {1'b0, r_dvs};
        take      = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
        end else if (i_req.start) begin
            r_count <= lfpd_pkg::DIV_STEPS;
        end else if (r_count != 4'd0) begin
            r_count <= r_count - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // upper dividend bits are known to stay below the divisor
            r_rem <= {1'b0, i_req.dividend[23:13]};
            r_quo <= i_req.dividend[12:0];
            r_dvs <= i_req.divisor;
        end else if (r_count != 4'd0) begin
            r_rem <= take ? trial_sub[11:0] : trial[11:0];
            r_quo <= {r_quo[11:0], take};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = (r_count == 4'd0);

endmodule

// ===== rtl/line_follow_pid_drive.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_drive
// Line follower: sensor normalization, weighted line position, PID steering
// and clamped differential motor drive, in Q8 fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                        Handshake
//  --------  ---  ---------------------------------------------  -----------
//  i_cfg     in   index (3b), wdata (16b)                         valid/ready
//  i_sense   in   reading_a..reading_d (12b raw each)             valid/ready
//  o_drive   out  left_drive, right_drive, steer_correction,      valid/ready
//                 line_lost
//
//  Once an item is accepted, the block is not ready again until it has gone
//  through normalization on the shared multiplier, the 13-step serial
//  position divider, the PID products and the drive clamp. The divider is
//  the longest of these steps.
//  Reset (synchronous, active low) restores register defaults and clears the
//  stored error and error sum. The result sits in an output register; a new
//  item is taken while it waits, and only the final write stalls on it.
//  Configuration writes are always accepted.
//
module line_follow_pid_drive (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfpd_chan_if.sink i_cfg,
    lfpd_chan_if.sink i_sense,
    lfpd_chan_if.source o_drive
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    lfpd_pkg::t_cfg_regs cfg;

    lfpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg)
    );

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    lfpd_pkg::t_state r_state;
    lfpd_pkg::t_state n_state;
    logic [2:0]       r_step;

    lfpd_pkg::t_reading_item r_item;
    logic signed [12:0]      r_wsum;       // weighted level sum, +-4000
    logic [11:0]             r_sum;        // level sum, 0..4000
    logic                    r_lost;       // no level above threshold yet
    logic signed [13:0]      r_last_error;
    logic signed [15:0]      r_error_sum;
    logic signed [13:0]      r_err;
    logic signed [15:0]      r_diff;
    logic signed [34:0]      r_mix;        // PID product accumulator

    lfpd_pkg::t_drive_item r_out;
    logic                  r_out_valid;

    // control from the output decode
    logic               sense_ready;
    logic               out_load;
    lfpd_pkg::t_div_req div_req;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;

    // shared units
    logic signed [33:0] prod;
    logic [12:0]        quotient;
    logic               div_done;

    lfpd_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    lfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    logic accept;
    assign accept = i_sense.valid && sense_ready;

    assign i_sense.ready = sense_ready;
    assign o_drive.valid = r_out_valid;
    assign o_drive.data  = r_out;

    // ------------------------------------------------------------------
    // Normalization: pick the reading, subtract the black offset, x10
    // ------------------------------------------------------------------
    logic [11:0]        raw_sel;
    logic [11:0]        norm_d;
    logic [14:0]        norm_n;
    logic [10:0]        lvl_q;
    logic [9:0]         lvl;
    logic [1:0]         cons_idx;
    logic signed [13:0] lvl_s;
    logic signed [13:0] weighted;
    logic signed [13:0] wsum_ext;
    logic signed [13:0] wsum_nx;

    always_comb begin
        case (r_step[1:0])
            2'd0:    raw_sel = r_item.reading_a;
            2'd1:    raw_sel = r_item.reading_b;
            2'd2:    raw_sel = r_item.reading_c;
            default: raw_sel = r_item.reading_d;
        endcase
        // readings at or below the offset give level zero
        norm_d = (raw_sel > lfpd_pkg::RAW_LOW) ? (raw_sel - lfpd_pkg::RAW_LOW) : 12'd0;
        norm_n = {norm_d, 3'b000} + {2'b00, norm_d, 1'b0};

        // level of the sensor issued in the previous cycle
        lvl_q    = prod[lfpd_pkg::NORM_SHIFT + 10 : lfpd_pkg::NORM_SHIFT];
        lvl      = (lvl_q > {1'b0, lfpd_pkg::LEVEL_MAX}) ? lfpd_pkg::LEVEL_MAX : lvl_q[9:0];
        cons_idx = 2'(r_step - 3'd1);
        lvl_s    = {4'b0000, lvl};
        case (cons_idx)
            2'd0:    weighted = lvl_s + (lvl_s <<< 1);
            2'd1:    weighted = lvl_s;
            2'd2:    weighted = -lvl_s;
            default: weighted = -(lvl_s + (lvl_s <<< 1));
        endcase
        wsum_ext = {r_wsum[12], r_wsum};
        wsum_nx  = wsum_ext + weighted;
    end

    // ------------------------------------------------------------------
    // Position division setup: |wsum| * 2560 over the level sum
    // ------------------------------------------------------------------
    logic signed [12:0] wsum_neg;
    logic [11:0]        abs_w;
    logic [23:0]        dividend;

    always_comb begin
        wsum_neg = -r_wsum;
        abs_w    = r_wsum[12] ? wsum_neg[11:0] : r_wsum[11:0];
        dividend = {1'b0, abs_w, 11'd0} + {3'b000, abs_w, 9'd0};
    end

    // ------------------------------------------------------------------
    // Error, derivative and clamped error sum
    // ------------------------------------------------------------------
    logic signed [13:0] quo_s;
    logic signed [13:0] err_nx;
    logic signed [15:0] diff_nx;
    logic signed [16:0] acc_raw;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] acc_clamp;

    always_comb begin
        quo_s = {1'b0, quotient};
        if (r_lost) begin
            // steer hard toward the side the line was last seen on
            err_nx = (r_last_error > 14'sd0) ? lfpd_pkg::LOST_ERROR : -lfpd_pkg::LOST_ERROR;
        end else if (r_sum != 12'd0) begin
            err_nx = r_wsum[12] ? -quo_s : quo_s;
        end else begin
            err_nx = 14'sd0;
        end
        diff_nx = {{2{err_nx[13]}}, err_nx} - {{2{r_last_error[13]}}, r_last_error};
        acc_raw = {r_error_sum[15], r_error_sum} + {{3{err_nx[13]}}, err_nx};
        lim_pos = {2'b00, cfg.integral_limit};
        lim_neg = -lim_pos;
        if (acc_raw < lim_neg) begin
            acc_clamp = lim_neg;
        end else if (acc_raw > lim_pos) begin
            acc_clamp = lim_pos;
        end else begin
            acc_clamp = acc_raw;
        end
    end

    // ------------------------------------------------------------------
    // Correction saturation and motor drive clamp
    // ------------------------------------------------------------------
    function automatic logic [14:0] drive_clamp(
        input logic signed [17:0] x,
        input logic [14:0]        lo,
        input logic [14:0]        hi
    );
        logic signed [17:0] lo_s;
        logic signed [17:0] hi_s;
        logic [14:0]        res;
        lo_s = {3'b000, lo};
        hi_s = {3'b000, hi};
        // floor test first, so a floor above the ceiling wins for low values
        if (x < lo_s) begin
            res = lo;
        end else if (x > hi_s) begin
            res = hi;
        end else begin
            res = x[14:0];
        end
        return res;
    endfunction

    logic signed [34:0] mix_sh;
    logic signed [15:0] corr;
    logic signed [17:0] base_s;
    logic signed [17:0] corr_s;
    logic signed [17:0] left_raw;
    logic signed [17:0] right_raw;

    always_comb begin
        // arithmetic shift floors toward minus infinity
        mix_sh = r_mix >>> lfpd_pkg::MIX_FRAC;
        if (mix_sh > 35'sd32767) begin
            corr = 16'sh7FFF;
        end else if (mix_sh < -35'sd32768) begin
            corr = -16'sh8000;
        end else begin
            corr = mix_sh[15:0];
        end
        base_s    = {3'b000, cfg.base_drive};
        corr_s    = {{2{corr[15]}}, corr};
        left_raw  = base_s - corr_s;
        right_raw = base_s + corr_s;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfpd_pkg::ST_IDLE:  if (accept) n_state = lfpd_pkg::ST_NORM;
            lfpd_pkg::ST_NORM:  if (r_step == 3'd4) n_state = lfpd_pkg::ST_SETUP;
            lfpd_pkg::ST_SETUP: n_state = lfpd_pkg::ST_DIV;
            lfpd_pkg::ST_DIV:   if (div_done) n_state = lfpd_pkg::ST_ERR;
            lfpd_pkg::ST_ERR:   n_state = lfpd_pkg::ST_PID;
            lfpd_pkg::ST_PID:   if (r_step == 3'd3) n_state = lfpd_pkg::ST_DRIVE;
            lfpd_pkg::ST_DRIVE: if (out_load) n_state = lfpd_pkg::ST_IDLE;
            default:            n_state = lfpd_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Output decode: handshakes, divider start, multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        sense_ready      = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = dividend;
        div_req.divisor  = r_sum;
        mul_a            = 17'sd0;
        mul_b            = 17'sd0;
        case (r_state)
            lfpd_pkg::ST_IDLE: begin
                sense_ready = 1'b1;
            end
            lfpd_pkg::ST_NORM: begin
                mul_a = {2'b00, norm_n};
                mul_b = lfpd_pkg::NORM_RECIP;
            end
            lfpd_pkg::ST_SETUP: begin
                div_req.start = 1'b1;
            end
            lfpd_pkg::ST_PID: begin
                // P, then I on the updated sum, then D
                case (r_step)
                    3'd0: begin
                        mul_a = {1'b0, cfg.gain_p};
                        mul_b = {{3{r_err[13]}}, r_err};
                    end
                    3'd1: begin
                        mul_a = {1'b0, cfg.gain_i};
                        mul_b = {r_error_sum[15], r_error_sum};
                    end
                    default: begin
                        mul_a = {1'b0, cfg.gain_d};
                        mul_b = {r_diff[15], r_diff};
                    end
                endcase
            end
            lfpd_pkg::ST_DRIVE: begin
                // hold the result until the output register frees up
                out_load = !r_out_valid || o_drive.ready;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lfpd_pkg::ST_IDLE;
            r_step       <= 3'd0;
            r_last_error <= 14'sd0;
            r_error_sum  <= 16'sd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                lfpd_pkg::ST_NORM: r_step <= r_step + 3'd1;
                lfpd_pkg::ST_PID:  r_step <= r_step + 3'd1;
                default:           r_step <= 3'd0;
            endcase
            if (r_state == lfpd_pkg::ST_ERR) begin
                r_last_error <= err_nx;
                r_error_sum  <= acc_clamp[15:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_drive.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            lfpd_pkg::ST_IDLE: begin
                if (accept) begin
                    r_item <= i_sense.data;
                    r_wsum <= 13'sd0;
                    r_sum  <= 12'd0;
                    r_lost <= 1'b1;
                end
            end
            lfpd_pkg::ST_NORM: begin
                // accumulate the level of the previous sensor
                if (r_step != 3'd0) begin
                    r_wsum <= wsum_nx[12:0];
                    r_sum  <= r_sum + {2'b00, lvl};
                    if (lvl > cfg.dark_threshold) begin
                        r_lost <= 1'b0;
                    end
                end
            end
            lfpd_pkg::ST_ERR: begin
                r_err  <= err_nx;
                r_diff <= diff_nx;
                r_mix  <= 35'sd0;
            end
            lfpd_pkg::ST_PID: begin
                if (r_step != 3'd0) begin
                    r_mix <= r_mix + {prod[33], prod};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.left_drive       <= drive_clamp(left_raw, cfg.drive_floor, cfg.drive_ceiling);
            r_out.right_drive      <= drive_clamp(right_raw, cfg.drive_floor, cfg.drive_ceiling);
            r_out.steer_correction <= corr;
            r_out.line_lost        <= r_lost;
        end
    end

endmodule
